// ----- rtl/core/cpr_pkg.sv -----
// ============================================================================
// cpr_pkg: shared types and codes for the CLOCK page replacement block
// Request and result transfer types, operation codes and the command and
// status bundles between the controller and the datapath.
// ============================================================================
`default_nettype none

package cpr_pkg;

    // Operation codes carried in the request mode field
    localparam logic [2:0] MODE_ACCESS = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_EVICT  = 3'd2;
    localparam logic [2:0] MODE_LOOKUP = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // One request transfer
    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] page_id;
    } request_t;

    // One result transfer
    typedef struct packed {
        logic        hit;
        logic        evicted_valid;
        logic [31:0] evicted_page;
        logic [3:0]  slot;
        logic [4:0]  occupancy;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // latch request, reset scan and result fields
        logic search;      // one step of the linear page search
        logic set_ref;     // access hit: set reference bit of matched slot
        logic remove;      // remove hit: free matched slot
        logic mark_hit;    // lookup hit
        logic evict_step;  // one step of the clock hand sweep
        logic capture;     // latch victim page from the store read
        logic fill_step;   // one step of the free-slot search and fill
        logic clear;       // empty all slots
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic match;     // compared slot is occupied and holds the page
        logic scan_end;  // last slot was compared
        logic full;      // every slot occupied
        logic empty;     // no slot occupied
        logic victim;    // slot under the hand is occupied, reference clear
        logic free;      // slot under the hand is empty
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/cpr_ctrl.sv -----
// ============================================================================
// cpr_ctrl: sequencer for the CLOCK page replacement block
// Steps each request through those of search, hand sweep, victim capture and
// fill that its mode needs, then presents the result for one cycle.
// ============================================================================
`default_nettype none

module cpr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [2:0]          mode,
    input  wire cpr_pkg::dp_status_t status,
    output cpr_pkg::ctrl_cmd_t       cmd,
    output logic                     busy,
    output logic                     done
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_EVICT  = 3'd2;
    localparam logic [2:0] ST_EVCAP  = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] mode_reg, mode_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE, ST_DONE:
            begin
                state_next = ST_IDLE;
                if (start)
                begin
                    cmd.load  = 1'b1;
                    mode_next = mode;
                    case (mode)
                        cpr_pkg::MODE_ACCESS, cpr_pkg::MODE_REMOVE, cpr_pkg::MODE_LOOKUP:
                            state_next = ST_SEARCH;
                        cpr_pkg::MODE_EVICT:
                            state_next = status.empty ? ST_DONE : ST_EVICT;
                        cpr_pkg::MODE_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            state_next = ST_DONE;
                        end
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (status.match)
                begin
                    state_next = ST_DONE;
                    case (mode_reg)
                        cpr_pkg::MODE_ACCESS: cmd.set_ref  = 1'b1;
                        cpr_pkg::MODE_REMOVE: cmd.remove   = 1'b1;
                        default:              cmd.mark_hit = 1'b1;
                    endcase
                end
                else if (status.scan_end)
                begin
                    if (mode_reg == cpr_pkg::MODE_ACCESS)
                        state_next = status.full ? ST_EVICT : ST_FILL;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_EVICT:
            begin
                cmd.evict_step = 1'b1;
                if (status.victim)
                    state_next = ST_EVCAP;
            end
            ST_EVCAP:
            begin
                cmd.capture = 1'b1;
                state_next  = (mode_reg == cpr_pkg::MODE_ACCESS) ? ST_FILL : ST_DONE;
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.free)
                    state_next = ST_DONE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= cpr_pkg::MODE_ACCESS;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    // A new request may be taken while the previous result is shown
    assign busy = (state_reg != ST_IDLE) && (state_reg != ST_DONE);
    assign done = (state_reg == ST_DONE);

`ifndef SYNTHESIS
    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !start) |=> state_reg == ST_IDLE)
        else $error("result strobe held past one cycle");
    a_capture_after_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVCAP) |-> $past(state_reg == ST_EVICT && status.victim))
        else $error("victim capture without a victim");
    a_fill_only_access: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> mode_reg == cpr_pkg::MODE_ACCESS)
        else $error("fill entered for a non-access request");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/cpr_datapath.sv -----
// ============================================================================
// cpr_datapath: slot storage and clock hand for the page replacement block
// Page store memory, occupied and reference bits, hand, count, the search
// compare pipeline and the result registers.
// ============================================================================
`default_nettype none

module cpr_datapath #(
    parameter int CAPACITY  = 16,
    parameter int PAGE_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [31:0]        page_id,
    input  wire cpr_pkg::ctrl_cmd_t cmd,
    output cpr_pkg::dp_status_t     status,
    output cpr_pkg::result_t        result
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // Page store, read data registered
    logic [PAGE_BITS-1:0] mem [CAPACITY];
    logic [PAGE_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;

    logic [PAGE_BITS-1:0] pid_reg, pid_next;
    logic [IDX_W-1:0]     scan_reg, scan_next;
    logic                 issue_left_reg, issue_left_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]     hand_reg, hand_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CAPACITY-1:0]  occ_reg, occ_next;
    logic [CAPACITY-1:0]  ref_reg, ref_next;
    logic                 hit_reg, hit_next;
    logic                 evv_reg, evv_next;
    logic [PAGE_BITS-1:0] evp_reg, evp_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;

    logic [IDX_W-1:0]     hand_succ;
    logic                 occ_h;
    logic                 ref_h;
    logic                 match;
    logic [31:0]          slot_wide;
    logic [63:0]          evp_wide;

    assign hand_succ = (hand_reg == LAST_IDX) ? '0 : hand_reg + IDX_ONE;
    assign occ_h     = occ_reg[hand_reg];
    assign ref_h     = ref_reg[hand_reg];
    assign match     = cmp_valid_reg && occ_reg[cmp_idx_reg] && (rd_data_reg == pid_reg);
    assign rd_addr   = cmd.evict_step ? hand_reg : scan_reg;

    // Status back to the controller
    assign status.match    = match;
    assign status.scan_end = cmp_valid_reg && (cmp_idx_reg == LAST_IDX);
    assign status.full     = (count_reg == CNT_FULL);
    assign status.empty    = (count_reg == '0);
    assign status.victim   = occ_h && !ref_h;
    assign status.free     = !occ_h;

    // Next-state logic for all commands
    always_comb
    begin
        pid_next        = pid_reg;
        scan_next       = scan_reg;
        issue_left_next = issue_left_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        hand_next       = hand_reg;
        count_next      = count_reg;
        occ_next        = occ_reg;
        ref_next        = ref_reg;
        hit_next        = hit_reg;
        evv_next        = evv_reg;
        evp_next        = evp_reg;
        slot_next       = slot_reg;
        wr_en           = 1'b0;

        if (cmd.load)
        begin
            pid_next        = PAGE_BITS'(page_id);
            scan_next       = '0;
            issue_left_next = 1'b1;
            cmp_valid_next  = 1'b0;
            hit_next        = 1'b0;
            evv_next        = 1'b0;
            evp_next        = '0;
            slot_next       = '0;
        end

        // search: issue one read, compare the previous one
        if (cmd.search)
        begin
            cmp_valid_next = issue_left_reg;
            cmp_idx_next   = scan_reg;
            if (issue_left_reg)
            begin
                if (scan_reg == LAST_IDX)
                    issue_left_next = 1'b0;
                else
                    scan_next = scan_reg + IDX_ONE;
            end
        end

        if (cmd.set_ref)
        begin
            ref_next[cmp_idx_reg] = 1'b1;
            hit_next              = 1'b1;
            slot_next             = cmp_idx_reg;
        end

        if (cmd.remove)
        begin
            occ_next[cmp_idx_reg] = 1'b0;
            ref_next[cmp_idx_reg] = 1'b0;
            count_next            = count_reg - CNT_ONE;
            hit_next              = 1'b1;
        end

        if (cmd.mark_hit)
            hit_next = 1'b1;

        // hand sweep: second chance or take the victim
        if (cmd.evict_step)
        begin
            ref_next[hand_reg] = 1'b0;
            hand_next          = hand_succ;
            if (occ_h && !ref_h)
            begin
                occ_next[hand_reg] = 1'b0;
                count_next         = count_reg - CNT_ONE;
                evv_next           = 1'b1;
            end
        end

        if (cmd.capture)
            evp_next = rd_data_reg;

        // fill the first free slot at or after the hand
        if (cmd.fill_step)
        begin
            hand_next = hand_succ;
            if (!occ_h)
            begin
                wr_en              = 1'b1;
                occ_next[hand_reg] = 1'b1;
                ref_next[hand_reg] = 1'b1;
                count_next         = count_reg + CNT_ONE;
                slot_next          = hand_reg;
            end
        end

        if (cmd.clear)
        begin
            occ_next   = '0;
            ref_next   = '0;
            count_next = '0;
            hand_next  = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg       <= '0;
            issue_left_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            hand_reg       <= '0;
            count_reg      <= '0;
            occ_reg        <= '0;
            ref_reg        <= '0;
            hit_reg        <= 1'b0;
            evv_reg        <= 1'b0;
        end
        else
        begin
            scan_reg       <= scan_next;
            issue_left_reg <= issue_left_next;
            cmp_valid_reg  <= cmp_valid_next;
            hand_reg       <= hand_next;
            count_reg      <= count_next;
            occ_reg        <= occ_next;
            ref_reg        <= ref_next;
            hit_reg        <= hit_next;
            evv_reg        <= evv_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pid_reg     <= pid_next;
        cmp_idx_reg <= cmp_idx_next;
        evp_reg     <= evp_next;
        slot_reg    <= slot_next;
    end

    // Page store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[hand_reg] <= pid_reg;
        rd_data_reg <= mem[rd_addr];
    end

    // Result fields
    assign slot_wide            = 32'(slot_reg);
    assign evp_wide             = 64'(evp_reg);
    assign result.hit           = hit_reg;
    assign result.evicted_valid = evv_reg;
    assign result.evicted_page  = evp_wide[31:0];
    assign result.slot          = slot_wide[3:0];
    assign result.occupancy     = 5'(count_reg);

`ifndef SYNTHESIS
    a_count_matches_occ: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) == $countones(occ_reg))
        else $error("count out of step with occupied bits");
    a_evict_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.evict_step |-> count_reg != '0)
        else $error("hand sweep with no occupied slot");
    a_fill_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_step |-> count_reg != CNT_FULL)
        else $error("fill with no free slot");
    a_hit_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.set_ref || cmd.remove || cmd.mark_hit) |-> match)
        else $error("hit update without a matching slot");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/clock_page_replacement.sv -----
// ============================================================================
// clock_page_replacement: CLOCK (second chance) page replacement
// Top level joining the sequencer and the slot datapath.
// ============================================================================
// Usage:
//   A request transfer (mode, page_id) is taken at a rising edge where start
//   is high and busy is low. Exactly one result transfer follows, shown on
//   result for one cycle while done is high; the receiver cannot stall it.
//   A new request may be started in the cycle its predecessor's result shows.
// Sequence per mode, start to done:
//   clear, evict on empty, unused modes: straight to done.
//   lookup, remove, access hit: linear search, one slot a cycle over the
//   page store read port, plus one compare stage.
//   evict: second-chance hand sweep to the first victim, then a victim read.
//   access miss: search, then a free-slot walk from the hand; when full,
//   the evict sweep and victim read come before the walk.
// The search and the hand walk share the single page store read port.
// Reset: all slots empty, hand and count zero; page store contents are left
// as they are and never used until written.
// ============================================================================
`default_nettype none

module clock_page_replacement #(
    parameter int CAPACITY  = 16,
    parameter int PAGE_BITS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire cpr_pkg::request_t request,
    output logic                   busy,
    output logic                   done,
    output cpr_pkg::result_t       result
);

    cpr_pkg::ctrl_cmd_t  cmd;
    cpr_pkg::dp_status_t status;

    // Sequencer
    cpr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (request.mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Slot storage and hand
    cpr_datapath #(
        .CAPACITY  (CAPACITY),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .page_id (request.page_id),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

endmodule

`default_nettype wire
